// File: design/i2p_pkg.sv
package i2p_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_UP_A  = 8'd65;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_LO_A  = 8'd97;
  localparam logic [7:0] CH_LO_Z  = 8'd122;
  localparam logic [7:0] CH_D0    = 8'd48;
  localparam logic [7:0] CH_D9    = 8'd57;
  localparam logic [7:0] CASE_OFS = 8'd32;

  // most results one item may deliver
  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    K_OPERAND,
    K_CLOSE,
    K_OPER,
    K_OTHER
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    kind_e      kind;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FEED,
    S_RELOAD,
    S_FLUSH,
    S_REVRD,
    S_REVCH,
    S_EMIT,
    S_EWAIT,
    S_DONE
  } state_e;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFS : c;
  endfunction

  function automatic logic [1:0] prio(input logic [7:0] c);
    priority if (c == CH_POW) prio = 2'd3;
    else if (c == CH_MUL || c == CH_DIV) prio = 2'd2;
    else if (c == CH_ADD || c == CH_SUB) prio = 2'd1;
    else prio = 2'd0;
  endfunction

  function automatic kind_e classify(input logic [7:0] c);
    priority if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_D0 && c <= CH_D9))
      classify = K_OPERAND;
    else if (c == CH_CLOSE) classify = K_CLOSE;
    else if (prio(c) != 2'd0) classify = K_OPER;
    else classify = K_OTHER;
  endfunction

endpackage

// File: design/infix_to_postfix_prefix_unit.sv
// Infix to postfix / prefix converter.
// s_axis: one infix character per item in tdata, tlast on the final one.
// m_axis: converted characters in tdata, tlast on the final one, tuser
//   carries the overflow flag of the expression.
// cfg: a write of cfg_data_i selects the mode (0 postfix, 1 prefix) and
//   clears the stack, buffer and overflow flag; cfg_ready_o is always high.
// A two-item queue sits after the input, so the input keeps accepting
// while the converter works or the output stalls, until the queue is full.
// Postfix steps per item: take from queue, classify, end of output,
// retire; each stack pop or dropped open bracket adds a stack memory
// read-back, each delivered result passes through the output buffer
// memory, and the last item adds a flush of the operators left.
// Prefix mode buffers characters and converts on the last one: a
// reversed read of the buffer, the same per-character and pop steps as
// postfix, then the results.
// A stalled receiver holds the output register; conversion waits on it.
// Reset empties the queue, clears the stack pointer and buffer count and
// selects postfix.
module infix_to_postfix_prefix_unit #(
  parameter int MAX_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  output logic       m_axis_tuser,   // [0] overflow_error
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic           mode_q, mode_d, cfg_we;
  logic           q_valid, q_pop;
  i2p_pkg::item_t q_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign mode_d      = cfg_we ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else         mode_q <= mode_d;
  end

  i2p_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  i2p_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .clear_i     (cfg_we),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_valid) else $error("input stalled with empty queue");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !q_pop |=> q_valid) else $error("queued item lost");

endmodule

// File: design/i2p_front.sv
module i2p_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_char_i,
  input  logic           in_last_i,
  output logic           q_valid_o,
  output i2p_pkg::item_t q_item_o,
  input  logic           q_pop_i
);

  i2p_pkg::item_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic [7:0] uc;

  assign uc         = i2p_pkg::upcase(in_char_i);
  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = q_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{ch: uc, last: in_last_i, kind: i2p_pkg::classify(uc)};
    end
  end

endmodule

// File: design/i2p_back.sv
module i2p_back #(
  parameter int MAX_LEN = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mode_i,
  input  logic           clear_i,
  input  logic           q_valid_i,
  input  i2p_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_char_o,
  output logic           out_last_o,
  output logic           out_ovf_o
);

  localparam int AW  = $clog2(MAX_LEN);
  localparam int SPW = $clog2(MAX_LEN + 1);
  localparam int OBD = (MAX_LEN > i2p_pkg::MAX_RESULTS) ? MAX_LEN : i2p_pkg::MAX_RESULTS;
  localparam int OAW = $clog2(OBD);
  localparam int NW  = $clog2(2 * MAX_LEN + i2p_pkg::MAX_RESULTS + 3);
  localparam logic [SPW-1:0] SP_MAX = SPW'(MAX_LEN);
  localparam logic [NW-1:0]  N_MAX  = NW'(MAX_LEN);
  localparam logic [NW-1:0]  N_RES  = NW'(i2p_pkg::MAX_RESULTS);

  logic [7:0] stk [MAX_LEN];
  logic [7:0] ibuf [MAX_LEN];
  logic [7:0] obuf [OBD];

  i2p_pkg::state_e st_q, st_d, ret_q, ret_d;
  logic [SPW-1:0] sp_q, sp_d, cnt_q, cnt_d, k_q, k_d;
  logic [NW-1:0]  n_q, n_d, j_q, j_d;
  logic           seen_q, seen_d, last_q, last_d;
  logic [7:0]     cur_q, cur_d, tos_q, tos_d;
  logic [7:0]     stk_rd_q, ib_rd_q, ob_rd_q;
  logic           ov_q, ov_d, ol_q, ol_d, of_q, of_d;
  logic [7:0]     oc_q, oc_d;

  logic           stk_we, ib_we, ob_we, emit_en;
  logic [AW-1:0]  stk_wa, stk_ra, ib_wa, ib_ra;
  logic [OAW-1:0] ob_wa, ob_ra;
  logic [7:0]     stk_wd, emit_ch;
  logic [SPW-1:0] sp_m2, cnt_new;
  logic [NW-1:0]  m_res, rev_idx;
  i2p_pkg::kind_e kind;
  i2p_pkg::state_e feed_next;

  assign kind    = i2p_pkg::classify(cur_q);
  assign sp_m2   = sp_q - SPW'(2);
  assign m_res   = (n_q > N_RES) ? N_RES : n_q;
  assign rev_idx = n_q - NW'(1) - j_q;
  assign feed_next = mode_i ? i2p_pkg::S_REVRD :
                     (last_q ? i2p_pkg::S_FLUSH : i2p_pkg::S_EMIT);

  always_comb begin
    st_d = st_q; ret_d = ret_q; sp_d = sp_q; cnt_d = cnt_q; k_d = k_q;
    n_d = n_q; j_d = j_q; seen_d = seen_q; last_d = last_q; cur_d = cur_q;
    tos_d = tos_q;
    ov_d = ov_q && !out_ready_i; ol_d = ol_q; of_d = of_q; oc_d = oc_q;
    stk_we = 1'b0; stk_wa = sp_q[AW-1:0]; stk_wd = cur_q; stk_ra = sp_m2[AW-1:0];
    ib_we = 1'b0; ib_wa = cnt_q[AW-1:0]; ib_ra = k_q[AW-1:0] - AW'(1);
    emit_en = 1'b0; emit_ch = cur_q;
    // keep the read address on the pending result while the output stalls
    ob_ra = mode_i ? rev_idx[OAW-1:0] : j_q[OAW-1:0];
    q_pop_o = 1'b0; cnt_new = cnt_q;

    unique case (st_q)
      i2p_pkg::S_IDLE: begin
        if (q_valid_i) begin
          cur_d = q_item_i.ch;
          last_d = q_item_i.last;
          n_d = '0;
          j_d = '0;
          if (!mode_i) begin
            st_d = i2p_pkg::S_FEED;
          end else begin
            if (cnt_q < SP_MAX) begin
              ib_we = 1'b1;
              cnt_new = cnt_q + SPW'(1);
            end else begin
              seen_d = 1'b1;
            end
            cnt_d = cnt_new;
            if (q_item_i.last) begin
              sp_d = '0;
              k_d = cnt_new;
              st_d = i2p_pkg::S_REVRD;
            end else begin
              st_d = i2p_pkg::S_DONE;
            end
          end
        end
      end
      i2p_pkg::S_FEED: begin
        unique case (kind)
          i2p_pkg::K_OPERAND: begin
            emit_en = 1'b1;
            st_d = feed_next;
          end
          i2p_pkg::K_CLOSE: begin
            if (sp_q != '0 && tos_q != i2p_pkg::CH_OPEN) begin
              emit_en = 1'b1; emit_ch = tos_q;
              sp_d = sp_q - SPW'(1);
              ret_d = i2p_pkg::S_FEED; st_d = i2p_pkg::S_RELOAD;
            end else if (sp_q != '0) begin
              // drop the matching open bracket
              sp_d = sp_q - SPW'(1);
              ret_d = feed_next; st_d = i2p_pkg::S_RELOAD;
            end else begin
              st_d = feed_next;
            end
          end
          default: begin
            if (kind == i2p_pkg::K_OPER && sp_q != '0 &&
                i2p_pkg::prio(cur_q) <= i2p_pkg::prio(tos_q)) begin
              emit_en = 1'b1; emit_ch = tos_q;
              sp_d = sp_q - SPW'(1);
              ret_d = i2p_pkg::S_FEED; st_d = i2p_pkg::S_RELOAD;
            end else begin
              if (sp_q < SP_MAX) begin
                stk_we = 1'b1;
                sp_d = sp_q + SPW'(1);
                tos_d = cur_q;
              end else begin
                seen_d = 1'b1;
              end
              st_d = feed_next;
            end
          end
        endcase
      end
      i2p_pkg::S_RELOAD: begin
        tos_d = stk_rd_q;
        st_d = ret_q;
      end
      i2p_pkg::S_FLUSH: begin
        if (sp_q != '0) begin
          emit_en = 1'b1; emit_ch = tos_q;
          sp_d = sp_q - SPW'(1);
          ret_d = i2p_pkg::S_FLUSH; st_d = i2p_pkg::S_RELOAD;
        end else begin
          st_d = i2p_pkg::S_EMIT;
        end
      end
      i2p_pkg::S_REVRD: begin
        if (k_q == '0) begin
          st_d = i2p_pkg::S_FLUSH;
        end else begin
          k_d = k_q - SPW'(1);
          st_d = i2p_pkg::S_REVCH;
        end
      end
      i2p_pkg::S_REVCH: begin
        // reversed scan swaps the brackets
        priority if (ib_rd_q == i2p_pkg::CH_CLOSE) cur_d = i2p_pkg::CH_OPEN;
        else if (ib_rd_q == i2p_pkg::CH_OPEN) cur_d = i2p_pkg::CH_CLOSE;
        else cur_d = ib_rd_q;
        st_d = i2p_pkg::S_FEED;
      end
      i2p_pkg::S_EMIT: begin
        st_d = (j_q == m_res) ? i2p_pkg::S_DONE : i2p_pkg::S_EWAIT;
      end
      i2p_pkg::S_EWAIT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          oc_d = ob_rd_q;
          ol_d = last_q && (j_q + NW'(1) == m_res);
          of_d = seen_q || (n_q > N_RES);
          j_d = j_q + NW'(1);
          st_d = i2p_pkg::S_EMIT;
        end
      end
      i2p_pkg::S_DONE: begin
        q_pop_o = 1'b1;
        if (last_q) begin
          sp_d = '0; cnt_d = '0; seen_d = 1'b0;
        end
        st_d = i2p_pkg::S_IDLE;
      end
      default: st_d = i2p_pkg::S_IDLE;
    endcase

    ob_we = 1'b0;
    ob_wa = n_q[OAW-1:0];
    if (emit_en) begin
      if (!mode_i) begin
        ob_we = (n_q < N_RES);
        n_d = n_q + NW'(1);
      end else if (n_q < N_MAX) begin
        ob_we = 1'b1;
        n_d = n_q + NW'(1);
      end else begin
        seen_d = 1'b1;
      end
    end

    if (clear_i) begin
      sp_d = '0; cnt_d = '0; seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= i2p_pkg::S_IDLE;
      ret_q  <= i2p_pkg::S_IDLE;
      sp_q   <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      ret_q  <= ret_d;
      sp_q   <= sp_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; n_q <= n_d; j_q <= j_d; last_q <= last_d; cur_q <= cur_d;
    tos_q <= tos_d; oc_q <= oc_d; ol_q <= ol_d; of_q <= of_d;
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    stk_rd_q <= stk[stk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ib_we) ibuf[ib_wa] <= q_item_i.ch;
    ib_rd_q <= ibuf[ib_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ob_we) obuf[ob_wa] <= emit_ch;
    ob_rd_q <= obuf[ob_ra];
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_last_o  = ol_q;
  assign out_ovf_o   = of_q;

endmodule

// File: test/infix_to_postfix_prefix_unit_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_prefix_unit_tb;

  localparam int DEPTH      = 32;
  localparam int STREAM_CAP = 2 * DEPTH + 2;
  localparam int SETTLE     = 400;
  localparam int WD_LIMIT   = 6000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;

  infix_to_postfix_prefix_unit #(.MAX_LEN(DEPTH)) uut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } conv_char_t;

  // converter mirror
  conv_char_t pending_chars[$];
  logic [7:0] op_stack[DEPTH];
  logic [7:0] char_buf[DEPTH];
  logic [7:0] conv_out[$];
  int         op_sp, buf_cnt;
  bit         ovf_seen, prefix_mode;
  int         n_new;

  int  n_items, n_results, n_ovf_results, n_errors;
  bit  quiet;
  int  rx_stall;
  int  idle_cycles;

  function automatic int rank(input logic [7:0] c);
    case (c)
      i2p_pkg::CH_POW:                  return 3;
      i2p_pkg::CH_MUL, i2p_pkg::CH_DIV: return 2;
      i2p_pkg::CH_ADD, i2p_pkg::CH_SUB: return 1;
      default:                          return 0;
    endcase
  endfunction

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= i2p_pkg::CH_UP_A && c <= i2p_pkg::CH_UP_Z) ||
           (c >= i2p_pkg::CH_D0 && c <= i2p_pkg::CH_D9);
  endfunction

  function automatic void put_out(input logic [7:0] c, input int cap);
    if (conv_out.size() < cap) conv_out.push_back(c);
    else ovf_seen = 1'b1;
  endfunction

  function automatic void pop_op(input int cap);
    op_sp--;
    put_out(op_stack[op_sp], cap);
  endfunction

  function automatic void shunt(input logic [7:0] c, input int cap);
    int p;
    if (is_operand(c)) begin
      put_out(c, cap);
      return;
    end
    if (c == i2p_pkg::CH_CLOSE) begin
      while (op_sp > 0 && op_stack[op_sp-1] != i2p_pkg::CH_OPEN) pop_op(cap);
      if (op_sp > 0) op_sp--;
      return;
    end
    p = rank(c);
    if (p > 0)
      while (op_sp > 0 && p <= rank(op_stack[op_sp-1])) pop_op(cap);
    if (op_sp < DEPTH) begin
      op_stack[op_sp] = c;
      op_sp++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void drain_ops(input int cap);
    while (op_sp > 0) pop_op(cap);
  endfunction

  function automatic void clear_expr();
    op_sp = 0;
    buf_cnt = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void convert_char(input logic [7:0] raw, input bit last);
    logic [7:0] c, r;
    logic [7:0] rev[$];
    int n;
    c = (raw >= i2p_pkg::CH_LO_A && raw <= i2p_pkg::CH_LO_Z) ?
        raw - i2p_pkg::CASE_OFS : raw;
    conv_out.delete();
    n_new = 0;
    if (!prefix_mode) begin
      shunt(c, STREAM_CAP);
      if (last) drain_ops(STREAM_CAP);
    end else begin
      if (buf_cnt < DEPTH) begin
        char_buf[buf_cnt] = c;
        buf_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (!last) return;
      op_sp = 0;
      // scan backwards with brackets mirrored
      for (int k = buf_cnt - 1; k >= 0; k--) begin
        r = char_buf[k];
        if (r == i2p_pkg::CH_CLOSE) r = i2p_pkg::CH_OPEN;
        else if (r == i2p_pkg::CH_OPEN) r = i2p_pkg::CH_CLOSE;
        shunt(r, DEPTH);
      end
      drain_ops(DEPTH);
      foreach (conv_out[k]) rev.push_front(conv_out[k]);
      conv_out = rev;
    end
    n = conv_out.size();
    if (n > i2p_pkg::MAX_RESULTS) begin
      ovf_seen = 1'b1;
      n = i2p_pkg::MAX_RESULTS;
    end
    for (int k = 0; k < n; k++)
      pending_chars.push_back('{conv_out[k], last && (k + 1 == n), ovf_seen});
    n_new = n;
    if (last) clear_expr();
  endfunction

  // output side: random stalls and checking
  always @(posedge clk_i) begin
    conv_char_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tuser) n_ovf_results++;
      if (pending_chars.size() == 0) begin
        $error("unexpected item: out_char=%h last=%b", m_axis_tdata, m_axis_tlast);
        n_errors++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("out_char expected %h actual %h", want.ch, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last expected %b actual %b", want.last, m_axis_tlast);
          n_errors++;
        end
        if (m_axis_tuser !== want.ovf) begin
          $error("overflow_error expected %b actual %b", want.ovf, m_axis_tuser);
          n_errors++;
        end
      end
    end
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(1, 7) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input bit last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    convert_char(c, last);
    n_items++;
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(input bit m);
    drain_and_settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    prefix_mode = m;
    clear_expr();
  endtask

  task automatic send_expr(input logic [7:0] chars[$]);
    foreach (chars[k]) send_char(chars[k], k == chars.size() - 1);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'(i2p_pkg::CH_UP_A + $urandom_range(0, 25));
      1:       return 8'(i2p_pkg::CH_LO_A + $urandom_range(0, 25));
      default: return 8'(i2p_pkg::CH_D0 + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return i2p_pkg::CH_POW;
      1:       return i2p_pkg::CH_MUL;
      2:       return i2p_pkg::CH_DIV;
      3:       return i2p_pkg::CH_ADD;
      default: return i2p_pkg::CH_SUB;
    endcase
  endfunction

  task automatic random_expr();
    logic [7:0] e[$];
    int sel, terms, depth;
    sel = $urandom_range(0, 19);
    if (sel < 16) begin
      // mostly well-formed expression with random nesting, sometimes a stray close bracket
      terms = $urandom_range(1, 6);
      depth = 0;
      for (int t = 0; t < terms; t++) begin
        if (t > 0) e.push_back(rand_operator());
        if ($urandom_range(0, 3) == 0) begin
          e.push_back(i2p_pkg::CH_OPEN);
          depth++;
        end
        e.push_back(rand_operand());
        if (depth > 0 && $urandom_range(0, 2) == 0) begin
          e.push_back(i2p_pkg::CH_CLOSE);
          depth--;
        end
      end
      while (depth > 0) begin
        e.push_back(i2p_pkg::CH_CLOSE);
        depth--;
      end
      if ($urandom_range(0, 9) == 0) e.push_back(i2p_pkg::CH_CLOSE);
    end else if (sel < 19) begin
      repeat ($urandom_range(1, 6)) e.push_back(8'($urandom_range(0, 255)));
    end else begin
      // deep bracket run: stack, buffer and result overflow
      repeat ($urandom_range(30, 40)) e.push_back(i2p_pkg::CH_OPEN);
      e.push_back(rand_operand());
    end
    send_expr(e);
  endtask

  typedef struct {
    bit         mode;
    logic [7:0] ch;
    bit         last;
    bit         has_ref;
    logic [7:0] ref_ch;
  } stim_row_t;

  stim_row_t dir_rows[] = '{
    '{1'b0, "a",   1'b1, 1'b1, "A"},
    '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{1'b0, "a",   1'b0, 1'b0, 8'h00},
    '{1'b0, "+",   1'b0, 1'b0, 8'h00},
    '{1'b0, "b",   1'b0, 1'b0, 8'h00},
    '{1'b0, "*",   1'b0, 1'b0, 8'h00},
    '{1'b0, "c",   1'b0, 1'b0, 8'h00},
    '{1'b0, "-",   1'b0, 1'b0, 8'h00},
    '{1'b0, "(",   1'b0, 1'b0, 8'h00},
    '{1'b0, "9",   1'b0, 1'b0, 8'h00},
    '{1'b0, "^",   1'b0, 1'b0, 8'h00},
    '{1'b0, "0",   1'b0, 1'b0, 8'h00},
    '{1'b0, "^",   1'b0, 1'b0, 8'h00},
    '{1'b0, "z",   1'b0, 1'b0, 8'h00},
    '{1'b0, ")",   1'b0, 1'b0, 8'h00},
    '{1'b0, ")",   1'b0, 1'b0, 8'h00},
    '{1'b0, "/",   1'b0, 1'b0, 8'h00},
    '{1'b0, "{",   1'b1, 1'b0, 8'h00},
    '{1'b0, "(",   1'b0, 1'b0, 8'h00},
    '{1'b0, ")",   1'b1, 1'b0, 8'h00},
    '{1'b1, "(",   1'b0, 1'b0, 8'h00},
    '{1'b1, "a",   1'b0, 1'b0, 8'h00},
    '{1'b1, "+",   1'b0, 1'b0, 8'h00},
    '{1'b1, "b",   1'b1, 1'b1, "+"}
  };

  initial begin
    bit mode_seq[$];
    int first;
    clear_expr();
    prefix_mode = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != prefix_mode) set_mode(dir_rows[r].mode);
      send_char(dir_rows[r].ch, dir_rows[r].last);
      // results of this row are the newest entries of the queue
      first = pending_chars.size() - n_new;
      if (dir_rows[r].has_ref && (n_new == 0 ||
          pending_chars[first].ch !== dir_rows[r].ref_ch)) begin
        $error("out_char expected %h from row %0d, predictor disagrees", dir_rows[r].ref_ch, r);
        n_errors++;
      end
    end

    mode_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
    foreach (mode_seq[p]) begin
      set_mode(mode_seq[p]);
      while (n_items < 25 + 90 * (p + 1)) begin
        if (p == mode_seq.size() - 1 && n_items > 25 + 90 * p + 50) quiet = 1'b1;
        random_expr();
      end
    end

    drain_and_settle();
    $display("%0d chars sent in postfix and prefix phases, %0d converted chars checked",
             n_items, n_results);
    $display("%0d of them flagged overflow", n_ovf_results);
    if (n_errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
